/* hw/rtl/msmu_pkg.sv */
// ----------------------------------------------------------------------------
// msmu_pkg
// Shared constants, types and helpers of the scheduler metric unit.
// ----------------------------------------------------------------------------
`default_nettype none

package msmu_pkg;

    // action codes
    localparam logic [2:0] ACT_PRIO      = 3'd0;
    localparam logic [2:0] ACT_DECAY     = 3'd1;
    localparam logic [2:0] ACT_LOAD      = 3'd2;
    localparam logic [2:0] ACT_RECENT100 = 3'd3;
    localparam logic [2:0] ACT_LOAD100   = 3'd4;

    // fixed point constants (17.14)
    localparam int FRAC_BITS = 14;
    localparam logic [31:0] ONE_FP    = 32'd16384;
    localparam logic [31:0] HALF_FP   = 32'd8192;
    localparam logic [14:0] DECAY_MUL = 15'd16111;
    localparam logic [8:0]  READY_MUL = 9'd273;
    localparam logic [6:0]  SCALE_100 = 7'd100;

    // divider geometry: numerator |2L| * 2^14, divisor |2L + 1.0|
    localparam int NUM_W = 46;
    localparam int DEN_W = 32;

    // word riding alongside the divider
    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] recent;
        logic signed [5:0]  nice;
        logic               neg;
        logic               zero_den;
        logic signed [31:0] early;
    } t_side;

    // signed divide by 2^14, truncating toward zero
    function automatic logic signed [63:0] sdiv14(input logic signed [63:0] x);
        logic signed [63:0] b;
        b = x[63] ? (x + 64'sd16383) : x;
        return b >>> FRAC_BITS;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/msmu_divider.sv */
// ----------------------------------------------------------------------------
// msmu_divider
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module msmu_divider #(
    parameter int SIDE_W = 8
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_en,
    input  wire                            i_valid,
    input  wire  [msmu_pkg::NUM_W-1:0]     i_num,
    input  wire  [msmu_pkg::DEN_W-1:0]     i_den,
    input  wire  [SIDE_W-1:0]              i_side,
    output logic                           o_valid,
    output logic [msmu_pkg::NUM_W-1:0]     o_quo,
    output logic [SIDE_W-1:0]              o_side
);

    localparam int NB = msmu_pkg::NUM_W;
    localparam int DW = msmu_pkg::DEN_W;

    logic          r_v    [NB];
    logic [DW-1:0] r_rem  [NB];
    logic [NB-1:0] r_num  [NB];
    logic [NB-1:0] r_quo  [NB];
    logic [DW-1:0] r_den  [NB];
    logic [SIDE_W-1:0] r_side [NB];

    for (genvar k = 0; k < NB; k++) begin : g_stage
        logic          p_v;
        logic [DW-1:0] p_rem;
        logic [NB-1:0] p_num;
        logic [NB-1:0] p_quo;
        logic [DW-1:0] p_den;
        logic [SIDE_W-1:0] p_side;
        logic [DW:0]   cand;
        logic          ge;
        logic [DW:0]   diff;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_rem  = '0;
            assign p_num  = i_num;
            assign p_quo  = '0;
            assign p_den  = i_den;
            assign p_side = i_side;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_num  = r_num[k-1];
            assign p_quo  = r_quo[k-1];
            assign p_den  = r_den[k-1];
            assign p_side = r_side[k-1];
        end

        // shift in next numerator bit, trial subtract
        assign cand = {p_rem, p_num[NB-1]};
        assign ge   = (cand >= {1'b0, p_den});
        assign diff = cand - {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[DW-1:0] : cand[DW-1:0];
                r_num[k]  <= {p_num[NB-2:0], 1'b0};
                r_quo[k]  <= {p_quo[NB-2:0], ge};
                r_den[k]  <= p_den;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_v[NB-1];
    assign o_quo   = r_quo[NB-1];
    assign o_side  = r_side[NB-1];

endmodule

`default_nettype wire

/* hw/rtl/mlfqs_scheduler_metric_unit.sv */
// ----------------------------------------------------------------------------
// mlfqs_scheduler_metric_unit
// Scheduler metrics in 17.14 fixed point: priority, recent decay, load
// update and x100 rounding, one word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Pipeline: 2 operand stages, 46 divider stages set by the one-bit-per-stage
// quotient, and 3 finish stages between input accept and output word.
// Throughput: one word per cycle; the whole pipe holds while the output
// word is stalled. Reset clears all valid bits; no clearing pass.
`default_nettype none

module mlfqs_scheduler_metric_unit #(
    parameter int TOP_PRIORITY = 63
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire  [2:0]         i_action,
    input  wire  signed [31:0] i_recent_usage,
    input  wire  signed [5:0]  i_niceness,
    input  wire  [30:0]        i_load_average,
    input  wire  [15:0]        i_ready_count,
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [31:0] o_value
);

    localparam int SIDE_W = $bits(msmu_pkg::t_side);
    localparam logic signed [31:0] TOP_S = 32'(TOP_PRIORITY);
    localparam logic signed [31:0] TOP_FP = 32'(TOP_PRIORITY * 16384);

    logic r_out_valid;
    logic en;
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = r_out_valid && i_stall;

    // stage 1: input register
    logic               r1_v;
    logic [2:0]         r1_action;
    logic signed [31:0] r1_recent;
    logic signed [5:0]  r1_nice;
    logic [30:0]        r1_load;
    logic [15:0]        r1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_action <= i_action;
            r1_recent <= i_recent_usage;
            r1_nice   <= i_niceness;
            r1_load   <= i_load_average;
            r1_ready  <= i_ready_count;
        end
    end

    // stage 2: products and divider operands
    logic [31:0] t1, t2, x100_src, x100_w;
    logic [45:0] load_prod;
    logic [24:0] ready_prod;
    logic [31:0] t1_mag, t2_mag;

    assign t1 = {r1_load[30:0], 1'b0};
    assign t2 = t1 + msmu_pkg::ONE_FP;
    assign t1_mag = t1[31] ? (~t1 + 32'd1) : t1;
    assign t2_mag = t2[31] ? (~t2 + 32'd1) : t2;
    assign x100_src = (r1_action == msmu_pkg::ACT_RECENT100) ? r1_recent : {1'b0, r1_load};
    assign x100_w = 32'(x100_src * {25'd0, msmu_pkg::SCALE_100});
    assign load_prod = {15'd0, r1_load} * {31'd0, msmu_pkg::DECAY_MUL};
    assign ready_prod = {9'd0, r1_ready} * {16'd0, msmu_pkg::READY_MUL};

    logic               r2_v;
    logic [2:0]         r2_action;
    logic signed [31:0] r2_recent;
    logic signed [5:0]  r2_nice;
    logic [45:0]        r2_load_prod;
    logic [24:0]        r2_ready_prod;
    logic signed [31:0] r2_x100;
    logic [45:0]        r2_num;
    logic [31:0]        r2_den;
    logic               r2_neg;
    logic               r2_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_action     <= r1_action;
            r2_recent     <= r1_recent;
            r2_nice       <= r1_nice;
            r2_load_prod  <= load_prod;
            r2_ready_prod <= ready_prod;
            r2_x100       <= x100_w;
            r2_num        <= {t1_mag, 14'd0};
            r2_den        <= t2_mag;
            r2_neg        <= t1[31] ^ t2[31];
            r2_zero       <= (t2 == 32'd0);
        end
    end

    // finish the non-divide actions
    logic signed [31:0] q4, prio_raw, prio_div, prio_val;
    logic signed [31:0] load_val, rnd_in, rnd_val, early;

    always_comb begin
        q4 = r2_recent[31] ? ((r2_recent + 32'sd3) >>> 2) : (r2_recent >>> 2);
        prio_raw = TOP_FP - q4 - 32'(64'(r2_nice) <<< 15);
        prio_div = 32'(msmu_pkg::sdiv14(64'(prio_raw)));
        if (prio_div < 0) begin
            prio_val = '0;
        end else if (prio_div > TOP_S) begin
            prio_val = TOP_S;
        end else begin
            prio_val = prio_div;
        end

        load_val = 32'(r2_load_prod >> msmu_pkg::FRAC_BITS) + {7'd0, r2_ready_prod};

        rnd_in  = r2_x100[31] ? (r2_x100 - msmu_pkg::HALF_FP) : (r2_x100 + msmu_pkg::HALF_FP);
        rnd_val = 32'(msmu_pkg::sdiv14(64'(rnd_in)));

        unique case (r2_action)
            msmu_pkg::ACT_PRIO:      early = prio_val;
            msmu_pkg::ACT_LOAD:      early = load_val;
            msmu_pkg::ACT_RECENT100: early = rnd_val;
            msmu_pkg::ACT_LOAD100:   early = rnd_val;
            default:                 early = '0;
        endcase
    end

    msmu_pkg::t_side side_in, side_out;
    logic [SIDE_W-1:0] side_out_bits;
    logic              dv_valid;
    logic [45:0]       dv_quo;

    assign side_in.action   = r2_action;
    assign side_in.recent   = r2_recent;
    assign side_in.nice     = r2_nice;
    assign side_in.neg      = r2_neg;
    assign side_in.zero_den = r2_zero;
    assign side_in.early    = early;

    // divide stages
    msmu_divider #(
        .SIDE_W(SIDE_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r2_v),
        .i_num  (r2_num),
        .i_den  (r2_den),
        .i_side (side_in),
        .o_valid(dv_valid),
        .o_quo  (dv_quo),
        .o_side (side_out_bits)
    );

    assign side_out = side_out_bits;

    // stage A: signed, wrapped quotient
    logic               ra_v;
    logic signed [31:0] ra_q;
    msmu_pkg::t_side    ra_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_v <= 1'b0;
        end else if (en) begin
            ra_v <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            ra_q    <= side_out.zero_den ? 32'sd0 :
                       side_out.neg ? -$signed(dv_quo[31:0]) : $signed(dv_quo[31:0]);
            ra_side <= side_out;
        end
    end

    // stage B: q * recent
    logic               rb_v;
    logic signed [63:0] rb_prod;
    msmu_pkg::t_side    rb_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rb_v <= 1'b0;
        end else if (en) begin
            rb_v <= ra_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rb_prod <= 64'(ra_q) * 64'(ra_side.recent);
            rb_side <= ra_side;
        end
    end

    // stage C: output word
    logic signed [31:0] decay_val;
    logic [2:0]         r_out_act;
    logic signed [31:0] r_value;

    assign decay_val = 32'(msmu_pkg::sdiv14(rb_prod)) + 32'(64'(rb_side.nice) <<< 14);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= rb_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_act <= rb_side.action;
            r_value   <= (rb_side.action == msmu_pkg::ACT_DECAY) ? decay_val : rb_side.early;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_value;

    // checks
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output register");

    a_prio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_out_act == msmu_pkg::ACT_PRIO) |-> (o_value >= 0 && o_value <= TOP_S))
        else $error("priority out of range");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_out_act != msmu_pkg::ACT_PRIO && r_out_act != msmu_pkg::ACT_DECAY &&
         r_out_act != msmu_pkg::ACT_LOAD && r_out_act != msmu_pkg::ACT_RECENT100 &&
         r_out_act != msmu_pkg::ACT_LOAD100) |-> (o_value == 0))
        else $error("unused action gave nonzero word");

endmodule

`default_nettype wire
